[rtl/tscpm_pkg.sv]
// Shared types and constants for the TS continuity and PCR monitor.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tscpm_pkg;

   localparam int PID_W     = 13;
   localparam int CC_W      = 4;
   localparam int PID_COUNT = 1 << PID_W;
   localparam int BASE_W    = 33;
   localparam int EXT_W     = 9;
   localparam int PCR_W     = 42;
   localparam int WALL_W    = 48;
   localparam int CMP_W     = 51;

   localparam logic [7:0] SYNC_VALUE    = 8'h47;
   localparam int         FLAG_DISC_BIT = 7;
   localparam int         FLAG_PCR_BIT  = 4;
   localparam logic [7:0] MIN_PCR_ALEN  = 8'd7;

   localparam logic [PCR_W-1:0] PCR_MULT    = PCR_W'(300);
   localparam logic [PCR_W-1:0] PCR_WRAP    = 42'd2576980377600;
   localparam logic [CMP_W-1:0] TICKS_PER_S = CMP_W'(27000000);
   localparam logic [CMP_W-1:0] HALF_S      = CMP_W'(27000000 / 2);
   localparam logic [PCR_W-1:0] D_LIMIT     = PCR_W'(60 * 27000000);

   // Register stages from accept to the result queue, and queue depth.
   localparam int PIPE_STAGES = 6;
   localparam int FIFO_DEPTH  = 8;
   localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
   localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic            valid;
      logic [PID_W-1:0] pid;
      logic [CC_W-1:0]  cc;
      logic            upd;
      logic            disc;
   } cc_req_type;

   typedef struct packed {
      logic              take;
      logic [BASE_W-1:0] base;
      logic [EXT_W-1:0]  ext;
      logic [WALL_W-1:0] wall;
   } pcr_req_type;

   // sync_error sits in the lowest bit.
   typedef struct packed {
      logic pcr_jump;
      logic pcr_checked;
      logic discontinuity_seen;
      logic continuity_error;
      logic sync_error;
   } result_type;

endpackage

[rtl/tscpm_cc_track.sv]
// Per-PID continuity tracking over a 8192 x 5 synchronous memory.
// Depends on tscpm_pkg; clears the memory after reset.
`timescale 1ns / 1ps

module tscpm_cc_track
   import tscpm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cc_req_type req,
   output logic       busy,
   output logic       cerr
);

   logic [CC_W:0]    mem [PID_COUNT];
   logic [CC_W:0]    rd_data_ff;
   cc_req_type       s1_ff;
   logic             wr_vld_ff;
   logic [PID_W-1:0] wr_pid_ff;
   logic [CC_W-1:0]  wr_cc_ff;
   logic             clr_busy_ff;
   logic [PID_W-1:0] clr_cnt_ff;

   logic             we;
   logic [PID_W-1:0] waddr;
   logic [CC_W:0]    wdata;
   logic [CC_W:0]    entry;
   logic [CC_W-1:0]  next_cc;

   // Memory: one read at accept, one write in the cycle after.
   always_ff @(posedge clock) begin
      if (req.valid) begin
         rd_data_ff <= mem[req.pid];
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff.pid  <= req.pid;
      s1_ff.cc   <= req.cc;
      s1_ff.upd  <= req.upd;
      s1_ff.disc <= req.disc;
      wr_pid_ff  <= s1_ff.pid;
      wr_cc_ff   <= s1_ff.cc;
      if (reset) begin
         s1_ff.valid <= 1'b0;
         wr_vld_ff   <= 1'b0;
         clr_busy_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else begin
         s1_ff.valid <= req.valid;
         wr_vld_ff   <= s1_ff.valid & s1_ff.upd;
         if (clr_busy_ff) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == PID_W'(PID_COUNT - 1)) begin
               clr_busy_ff <= 1'b0;
            end
         end
      end
   end

   always_comb begin
      we    = clr_busy_ff | (s1_ff.valid & s1_ff.upd);
      waddr = clr_busy_ff ? clr_cnt_ff : s1_ff.pid;
      wdata = clr_busy_ff ? '0 : {1'b1, s1_ff.cc};
      // The item just ahead wrote at the same edge this one was read,
      // so the memory returned the older entry.
      if (wr_vld_ff && (wr_pid_ff == s1_ff.pid)) begin
         entry = {1'b1, wr_cc_ff};
      end else begin
         entry = rd_data_ff;
      end
      next_cc = entry[CC_W-1:0] + 1'b1;
      cerr    = s1_ff.valid & s1_ff.upd & entry[CC_W] & ~s1_ff.disc &
                (s1_ff.cc != next_cc);
   end

   assign busy = clr_busy_ff;

   a_no_item_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !req.valid)
      else $error("item entered during memory clear");

   a_clear_ends_at_top: assert property (@(posedge clock) disable iff (reset)
      $fell(clr_busy_ff) |-> $past(clr_cnt_ff) == PID_W'(PID_COUNT - 1))
      else $error("memory clear ended early");

endmodule

[rtl/tscpm_pcr_check.sv]
// PCR plausibility pipeline: scales the PCR, reduces it and checks the
// advance against the wall-time difference. Depends on tscpm_pkg.
`timescale 1ns / 1ps

module tscpm_pcr_check
   import tscpm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  pcr_req_type req,
   output logic        jump
);

   logic              p1_take_ff, p2_take_ff, p3_take_ff, p4_take_ff, p5_en_ff, p6_en_ff;
   logic [BASE_W-1:0] p1_base_ff;
   logic [EXT_W-1:0]  p1_ext_ff, p2_ext_ff;
   logic [WALL_W-1:0] p1_wall_ff, p2_wall_ff, p3_wall_ff, p4_wall_ff;
   logic [PCR_W-1:0]  p2_prod_ff, p3_pcr_ff, p4_red_ff;
   logic [PCR_W-1:0]  p5_d_ff;
   logic [WALL_W-1:0] p5_w_ff;
   logic              p5_borrow_ff;
   logic              p6_base_ok_ff;
   logic [CMP_W-1:0]  p6_d_ff, p6_lim5w_ff, p6_lim10d_ff, p6_w2_ff;
   logic [PCR_W-1:0]  prev_pcr_ff;
   logic [WALL_W-1:0] prev_wall_ff;
   logic              prev_valid_ff;

   logic [PCR_W-1:0]  p2_prod_in, p3_pcr_in, p4_red_in, p5_d_in;
   logic [WALL_W:0]   wdiff;
   logic [CMP_W-1:0]  d_w, w_w;

   always_comb begin
      p2_prod_in = {{(PCR_W-BASE_W){1'b0}}, p1_base_ff} * PCR_MULT;
      p3_pcr_in  = p2_prod_ff + {{(PCR_W-EXT_W){1'b0}}, p2_ext_ff};
      p4_red_in  = (p3_pcr_ff >= PCR_WRAP) ? p3_pcr_ff - PCR_WRAP : p3_pcr_ff;
      // Advance modulo the PCR wrap; both sides are already reduced.
      p5_d_in    = (p4_red_ff >= prev_pcr_ff) ? p4_red_ff - prev_pcr_ff
                                              : p4_red_ff + (PCR_WRAP - prev_pcr_ff);
      wdiff      = {1'b0, p4_wall_ff} - {1'b0, prev_wall_ff};
      d_w        = {{(CMP_W-PCR_W){1'b0}}, p5_d_ff};
      w_w        = {{(CMP_W-WALL_W){1'b0}}, p5_w_ff};
      jump       = p6_en_ff & ~(p6_base_ok_ff & (p6_d_ff < p6_lim5w_ff) &
                                (p6_lim10d_ff > p6_w2_ff));
   end

   always_ff @(posedge clock) begin
      p1_base_ff    <= req.base;
      p1_ext_ff     <= req.ext;
      p1_wall_ff    <= req.wall;
      p2_prod_ff    <= p2_prod_in;
      p2_ext_ff     <= p1_ext_ff;
      p2_wall_ff    <= p1_wall_ff;
      p3_pcr_ff     <= p3_pcr_in;
      p3_wall_ff    <= p2_wall_ff;
      p4_red_ff     <= p4_red_in;
      p4_wall_ff    <= p3_wall_ff;
      p5_d_ff       <= p5_d_in;
      p5_w_ff       <= wdiff[WALL_W-1:0];
      p5_borrow_ff  <= wdiff[WALL_W];
      p6_base_ok_ff <= ~p5_borrow_ff & (p5_w_ff != '0) & (p5_d_ff != '0) &
                       (p5_d_ff < D_LIMIT);
      p6_d_ff       <= d_w;
      p6_lim5w_ff   <= {w_w[CMP_W-3:0], 2'b00} + w_w + HALF_S;
      p6_lim10d_ff  <= {d_w[CMP_W-4:0], 3'b000} + {d_w[CMP_W-2:0], 1'b0} + TICKS_PER_S;
      p6_w2_ff      <= {w_w[CMP_W-2:0], 1'b0};
      if (p4_take_ff) begin
         prev_pcr_ff  <= p4_red_ff;
         prev_wall_ff <= p4_wall_ff;
      end
      if (reset) begin
         p1_take_ff    <= 1'b0;
         p2_take_ff    <= 1'b0;
         p3_take_ff    <= 1'b0;
         p4_take_ff    <= 1'b0;
         p5_en_ff      <= 1'b0;
         p6_en_ff      <= 1'b0;
         prev_valid_ff <= 1'b0;
      end else begin
         p1_take_ff <= req.take;
         p2_take_ff <= p1_take_ff;
         p3_take_ff <= p2_take_ff;
         p4_take_ff <= p3_take_ff;
         p5_en_ff   <= p4_take_ff & prev_valid_ff;
         p6_en_ff   <= p5_en_ff;
         if (p4_take_ff) begin
            prev_valid_ff <= 1'b1;
         end
      end
   end

   a_prev_valid_sticky: assert property (@(posedge clock) disable iff (reset)
      !$fell(prev_valid_ff))
      else $error("previous PCR lost outside reset");

endmodule

[rtl/ts_continuity_pcr_monitor_core.sv]
// Top level of the TS continuity and PCR monitor: header decode, result
// pipeline and output queue. Depends on tscpm_pkg, tscpm_cc_track, tscpm_pcr_check.
`timescale 1ns / 1ps
//
//  channel   dir  handshake            payload
//  req_      in   req_tvalid/tready    req_tdata[132:0] one packet header
//  rsp_      out  rsp_tvalid/tready    rsp_tdata[4:0]   five check flags
//  csr_      in   csr_we               csr_wdata[12:0]  PCR PID, 0 = off
//
//  One item per cycle while req_tready is high; a result passes the result stages
//  into the output queue after its item is accepted and can be taken in the cycle after.
//  Latency is set by the PCR path (multiply, add extension, reduce, difference, compare).
//  After reset every entry of the PID memory is cleared while req_tready is held low.
//  An 8-entry result queue with credit counting keeps req_tready high while
//  results wait; once 8 items are outstanding req_tready drops.

module ts_continuity_pcr_monitor_core
   import tscpm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // sync_byte[7:0], pid[20:8], adapt_control[22:21], cont_counter[26:23],
   // adapt_length[34:27], adapt_flags[42:35], pcr_base[75:43],
   // pcr_extension[84:76], wall_time[132:85], zero fill above
   input  logic [135:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // sync_error[0], continuity_error[1], discontinuity_seen[2],
   // pcr_checked[3], pcr_jump[4], zero fill above
   output logic [7:0]   rsp_tdata,
   input  logic         csr_we,
   input  logic [12:0]  csr_wdata
);

   logic [PID_W-1:0]       pcr_pid_ff;
   logic [PIPE_STAGES-1:0] vld_ff;
   result_type             res_ff [PIPE_STAGES];
   result_type             fifo_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]       fill_ff, credit_ff;

   logic              accept, pop, push, busy, cerr, jump;
   logic [7:0]        sync_byte, alen, aflags;
   logic [PID_W-1:0]  pid;
   logic [1:0]        afc;
   logic [CC_W-1:0]   cc;
   logic              sync_ok, disc, take;
   result_type        head, push_data, res1_in;
   cc_req_type        cc_req;
   pcr_req_type       pcr_req;

   always_comb begin
      sync_byte = req_tdata[7:0];
      pid       = req_tdata[20:8];
      afc       = req_tdata[22:21];
      cc        = req_tdata[26:23];
      alen      = req_tdata[34:27];
      aflags    = req_tdata[42:35];
      accept    = req_tvalid & req_tready;
      sync_ok   = (sync_byte == SYNC_VALUE);
      disc      = sync_ok & afc[1] & (alen != '0) & aflags[FLAG_DISC_BIT];
      take      = sync_ok & (pcr_pid_ff != '0) & (pid == pcr_pid_ff) & afc[1] &
                  (alen >= MIN_PCR_ALEN) & aflags[FLAG_PCR_BIT];

      head                    = '0;
      head.sync_error         = ~sync_ok;
      head.discontinuity_seen = disc;
      head.pcr_checked        = take;

      cc_req.valid = accept;
      cc_req.pid   = pid;
      cc_req.cc    = cc;
      cc_req.upd   = sync_ok & afc[0];
      cc_req.disc  = disc;

      pcr_req.take = accept & take;
      pcr_req.base = req_tdata[75:43];
      pcr_req.ext  = req_tdata[84:76];
      pcr_req.wall = req_tdata[132:85];

      res1_in                  = res_ff[0];
      res1_in.continuity_error = cerr;

      push               = vld_ff[PIPE_STAGES-1];
      push_data          = res_ff[PIPE_STAGES-1];
      push_data.pcr_jump = jump;
      pop                = rsp_tvalid & rsp_tready;
   end

   tscpm_cc_track u_cc_track (
      .clock (clock),
      .reset (reset),
      .req   (cc_req),
      .busy  (busy),
      .cerr  (cerr)
   );

   tscpm_pcr_check u_pcr_check (
      .clock (clock),
      .reset (reset),
      .req   (pcr_req),
      .jump  (jump)
   );

   // Result flags ride alongside the checks; continuity joins after stage 0.
   always_ff @(posedge clock) begin
      res_ff[0] <= head;
      res_ff[1] <= res1_in;
      for (int i = 2; i < PIPE_STAGES; i++) begin
         res_ff[i] <= res_ff[i-1];
      end
      if (push) begin
         fifo_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         pcr_pid_ff <= '0;
         vld_ff     <= '0;
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         fill_ff    <= '0;
         credit_ff  <= '0;
      end else begin
         if (csr_we) begin
            pcr_pid_ff <= csr_wdata;
         end
         vld_ff <= {vld_ff[PIPE_STAGES-2:0], accept};
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         fill_ff   <= fill_ff + CNT_W'(push) - CNT_W'(pop);
         credit_ff <= credit_ff + CNT_W'(accept) - CNT_W'(pop);
      end
   end

   assign req_tready = ~busy & (credit_ff < CNT_W'(FIFO_DEPTH));
   assign rsp_tvalid = (fill_ff != '0);
   assign rsp_tdata  = {3'b000, fifo_ff[rd_ptr_ff]};

   a_credit_balance: assert property (@(posedge clock) disable iff (reset)
      credit_ff == fill_ff + CNT_W'($countones(vld_ff)))
      else $error("credit count disagrees with items in flight");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (fill_ff != CNT_W'(FIFO_DEPTH)) || pop)
      else $error("result queue overflow");

endmodule
